FILE: hw/rtl/polyphonic_voice_allocator_macros.svh
// assertion macros shared by the voice allocator rtl
// depends on nothing; expects i_clk and i_rst_n in the including module
`ifndef POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PVA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pva assertion failed");

// next-cycle implication, disabled in reset
`define PVA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pva assertion failed");

`endif

FILE: hw/rtl/pva_pkg.sv
// shared types and codes for the voice allocator
// depends on nothing
`timescale 1ns / 1ps
package pva_pkg;
    localparam int VOICES_DEF = 15;
    localparam int NOTES_DEF  = 128;
    localparam int VOICE_W    = 4;
    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int ACT_W      = 3;
    localparam int ST_W       = 3;

    localparam logic [1:0] CMD_ON   = 2'd0;
    localparam logic [1:0] CMD_OFF  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [ACT_W-1:0] ACT_TRIGGER   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_RETRIGGER = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STEAL     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_MARKED    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FREED     = 3'd5;
    localparam logic [ACT_W-1:0] ACT_IGNORED   = 3'd6;

    localparam logic [ST_W-1:0] VS_OFF       = 3'd0;
    localparam logic [ST_W-1:0] VS_TRIGGER   = 3'd1;
    localparam logic [ST_W-1:0] VS_RETRIGGER = 3'd2;
    localparam logic [ST_W-1:0] VS_STEAL     = 3'd3;
    localparam logic [ST_W-1:0] VS_RELEASE   = 3'd4;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    typedef struct packed {
        logic pop;
        logic rm;
        logic push;
    } t_q_ctrl;

    typedef struct packed {
        logic load;
        logic set_st;
        logic unmap;
    } t_vc_ctrl;
endpackage

FILE: hw/rtl/polyphonic_voice_allocator.sv
// top level of the voice allocator: control sequencer, voice cells, three queues
// depends on pva_pkg, pva_voice_cell, pva_queue and the assertion macro header
//
// Each transfer in is one command. Note on and note off each give one result.
// A tick gives one result per voice in the released queue, one per cycle while
// the output register is free to take it, or none at all when the queue is
// empty; the released queue pops one voice at its head for each tick result.
// A result that waits in the output register stalls the work while it waits.
// Every voice is a cell that holds its note, velocity, status and map bit; the
// note-to-voice map is the match of the note against all cells. Free, released
// and playing voices sit in shifting slot rows, oldest first. A new command is
// taken while the last result still waits in the output register.
`timescale 1ns / 1ps
`include "polyphonic_voice_allocator_macros.svh"
module polyphonic_voice_allocator
    import pva_pkg::*;
#(
    parameter int VOICES = VOICES_DEF,
    parameter int NOTES  = NOTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [NOTE_W-1:0]  i_note,
    input  logic [VEL_W-1:0]   i_velocity,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [VOICE_W-1:0] o_voice,
    output logic [ACT_W-1:0]   o_action,
    output logic [NOTE_W-1:0]  o_old_note,
    output logic [VEL_W-1:0]   o_old_velocity,
    output logic               o_last
);
    localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW  = $clog2(VOICES + 1);

    t_state r_state, n_state;

    // accepted command
    logic [1:0]        r_cmd;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic [CW-1:0]     r_tick_n;

    // voice cells
    t_vc_ctrl [VOICES-1:0]          vc_ctrl;
    logic [ST_W-1:0]                vc_st_val;
    logic [VOICES-1:0][NOTE_W-1:0]  vc_note;
    logic [VOICES-1:0][VEL_W-1:0]   vc_vel;
    logic [VOICES-1:0][ST_W-1:0]    vc_st;
    logic [VOICES-1:0]              vc_match;

    // queues
    t_q_ctrl                      fq_ctrl, rq_ctrl, pq_ctrl;
    logic [VOICE_W-1:0]           fq_data, rq_data, pq_data;
    logic [VOICES-1:0][VOICE_W-1:0] fq_e, rq_e, pq_e;
    logic [CW-1:0]                fq_cnt, rq_cnt, pq_cnt;
    logic                         fq_found, rq_found, pq_found;
    logic [VIW-1:0]               fq_fidx, rq_fidx, pq_fidx;

    logic               go, hit, bad_note, done, emit, res_last;
    logic [VOICE_W-1:0] hv, v, res_voice;
    logic [ACT_W-1:0]   res_act;
    logic [NOTE_W-1:0]  res_on;
    logic [VEL_W-1:0]   res_ov;

    genvar g;
    generate
        for (g = 0; g < VOICES; g++) begin : g_cell
            pva_voice_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (vc_ctrl[g]),
                .i_key   (r_note),
                .i_vel   (r_vel),
                .i_st    (vc_st_val),
                .o_note  (vc_note[g]),
                .o_vel   (vc_vel[g]),
                .o_st    (vc_st[g]),
                .o_match (vc_match[g])
            );
        end
    endgenerate

    pva_queue #(.DEPTH(VOICES), .INIT_FULL(1'b1)) u_free_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (fq_ctrl), .i_rm_idx ('0),
        .i_push_data (fq_data), .i_key ('0), .o_entries (fq_e), .o_count (fq_cnt),
        .o_found (fq_found), .o_found_idx (fq_fidx)
    );

    pva_queue #(.DEPTH(VOICES), .INIT_FULL(1'b0)) u_rel_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (rq_ctrl), .i_rm_idx ('0),
        .i_push_data (rq_data), .i_key ('0), .o_entries (rq_e), .o_count (rq_cnt),
        .o_found (rq_found), .o_found_idx (rq_fidx)
    );

    // playing queue: oldest in slot zero, note off removes from the middle
    pva_queue #(.DEPTH(VOICES), .INIT_FULL(1'b0)) u_play_q (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (pq_ctrl), .i_rm_idx (pq_fidx),
        .i_push_data (pq_data), .i_key (hv), .o_entries (pq_e), .o_count (pq_cnt),
        .o_found (pq_found), .o_found_idx (pq_fidx)
    );

    // at most one cell maps a note, so an or of the matching indexes is the hit voice
    always_comb begin
        hv = '0;
        for (int i = 0; i < VOICES; i++) begin
            if (vc_match[i]) begin
                hv = hv | VOICE_W'(i);
            end
        end
        hit = |vc_match;
    end

    assign go       = (r_state == S_EXEC) && (!o_out_valid || i_out_ready);
    assign bad_note = {1'b0, r_note} >= (NOTE_W + 1)'(NOTES);

    always_comb begin
        vc_ctrl   = '0;
        vc_st_val = VS_OFF;
        fq_ctrl   = '0;
        rq_ctrl   = '0;
        pq_ctrl   = '0;
        fq_data   = '0;
        rq_data   = '0;
        pq_data   = '0;
        v         = '0;
        done      = 1'b0;
        emit      = 1'b0;
        res_last  = 1'b1;
        res_voice = '0;
        res_act   = ACT_IGNORED;
        res_on    = '0;
        res_ov    = '0;
        if (go) begin
            case (r_cmd)
                CMD_TICK: begin
                    if (r_tick_n == '0) begin
                        done = 1'b1;
                    end else begin
                        v            = rq_e[0];
                        rq_ctrl.pop  = 1'b1;
                        emit         = 1'b1;
                        res_voice    = v;
                        res_ov       = vc_vel[v[VIW-1:0]];
                        res_last     = (r_tick_n == CW'(1));
                        done         = res_last;
                        if (vc_st[v[VIW-1:0]] == VS_OFF) begin
                            // second tick since release: back to the free pool
                            vc_ctrl[v[VIW-1:0]].unmap = 1'b1;
                            fq_ctrl.push = 1'b1;
                            fq_data      = v;
                            res_act      = ACT_FREED;
                        end else begin
                            vc_ctrl[v[VIW-1:0]].set_st = 1'b1;
                            vc_st_val    = VS_OFF;
                            rq_ctrl.push = 1'b1;
                            rq_data      = v;
                            res_act      = ACT_MARKED;
                        end
                    end
                end
                CMD_ON: begin
                    done = 1'b1;
                    emit = 1'b1;
                    if (bad_note) begin
                        res_act = ACT_IGNORED;
                    end else if (hit) begin
                        vc_ctrl[hv[VIW-1:0]].set_st = 1'b1;
                        vc_st_val = VS_RETRIGGER;
                        res_voice = hv;
                        res_act   = ACT_RETRIGGER;
                        res_ov    = vc_vel[hv[VIW-1:0]];
                    end else if (pq_cnt != '0 || fq_cnt != '0 || rq_cnt != '0) begin
                        // oldest free, then oldest released, then oldest playing
                        if (fq_cnt != '0) begin
                            v           = fq_e[0];
                            fq_ctrl.pop = 1'b1;
                            res_act     = ACT_TRIGGER;
                            vc_st_val   = VS_TRIGGER;
                        end else if (rq_cnt != '0) begin
                            v           = rq_e[0];
                            rq_ctrl.pop = 1'b1;
                            res_act     = ACT_STEAL;
                            vc_st_val   = VS_STEAL;
                            res_on      = vc_note[v[VIW-1:0]];
                        end else begin
                            v           = pq_e[0];
                            pq_ctrl.pop = 1'b1;
                            res_act     = ACT_STEAL;
                            vc_st_val   = VS_STEAL;
                            res_on      = vc_note[v[VIW-1:0]];
                        end
                        vc_ctrl[v[VIW-1:0]].load   = 1'b1;
                        vc_ctrl[v[VIW-1:0]].set_st = 1'b1;
                        pq_ctrl.push = 1'b1;
                        pq_data      = v;
                        res_voice    = v;
                        res_ov       = vc_vel[v[VIW-1:0]];
                    end else begin
                        res_act = ACT_IGNORED;
                    end
                end
                CMD_OFF: begin
                    done = 1'b1;
                    emit = 1'b1;
                    if (!bad_note && hit && pq_found) begin
                        pq_ctrl.rm = 1'b1;
                        vc_ctrl[hv[VIW-1:0]].set_st = 1'b1;
                        vc_st_val    = VS_RELEASE;
                        rq_ctrl.push = 1'b1;
                        rq_data      = hv;
                        res_voice    = hv;
                        res_act      = ACT_RELEASE;
                        res_ov       = vc_vel[hv[VIW-1:0]];
                    end else begin
                        res_act = ACT_IGNORED;
                    end
                end
                default: begin
                    // unknown command
                    done    = 1'b1;
                    emit    = 1'b1;
                    res_act = ACT_IGNORED;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_tick_n    <= '0;
        end else begin
            r_state <= n_state;
            if (i_in_valid && o_in_ready) begin
                r_tick_n <= rq_cnt;
            end else if (go && r_cmd == CMD_TICK && r_tick_n != '0) begin
                r_tick_n <= r_tick_n - CW'(1);
            end
            if (go && emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd  <= i_cmd;
            r_note <= i_note;
            r_vel  <= i_velocity;
        end
        if (go && emit) begin
            o_voice        <= res_voice;
            o_action       <= res_act;
            o_old_note     <= res_on;
            o_old_velocity <= res_ov;
            o_last         <= res_last;
        end
    end

    // the counts of free, released and playing voices add up to the number of voices
    `PVA_ASSERT_IMPL(a_voice_conserve, 1'b1,
        (32'(fq_cnt) + 32'(rq_cnt) + 32'(pq_cnt)) == 32'(VOICES))
    // a note maps to at most one voice
    `PVA_ASSERT_IMPL(a_map_unique, 1'b1, $onehot0(vc_match))
    // while a tick result that is not the last one waits, the sequencer is busy
    `PVA_ASSERT_IMPL(a_tick_busy, o_out_valid && !o_last, r_state == S_EXEC)
endmodule

FILE: hw/rtl/pva_queue.sv
// ordered queue built from a row of shifting slots
// depends on pva_pkg
`timescale 1ns / 1ps
module pva_queue
    import pva_pkg::*;
#(
    parameter int DEPTH     = VOICES_DEF,
    parameter bit INIT_FULL = 1'b0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_q_ctrl                           i_ctrl,
    input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] i_rm_idx,
    input  logic [VOICE_W-1:0]                i_push_data,
    input  logic [VOICE_W-1:0]                i_key,
    output logic [DEPTH-1:0][VOICE_W-1:0]     o_entries,
    output logic [$clog2(DEPTH+1)-1:0]        o_count,
    output logic                              o_found,
    output logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] o_found_idx
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][VOICE_W-1:0] r_q, n_q, shifted;
    logic [CW-1:0] r_cnt, n_cnt, cnt_rm;
    logic [IW-1:0] rm_at;
    logic          rmv;

    // each slot at or above the leaving entry takes its upper neighbor
    always_comb begin
        rmv   = i_ctrl.pop | i_ctrl.rm;
        rm_at = i_ctrl.pop ? '0 : i_rm_idx;
        for (int i = 0; i < DEPTH; i++) begin
            if (rmv && (IW'(i) >= rm_at) && (i < DEPTH - 1)) begin
                shifted[i] = r_q[(i < DEPTH - 1) ? i + 1 : i];
            end else begin
                shifted[i] = r_q[i];
            end
        end
        cnt_rm = r_cnt - CW'(rmv);
        n_q    = shifted;
        n_cnt  = cnt_rm;
        if (i_ctrl.push && (cnt_rm < CW'(DEPTH))) begin
            n_q[cnt_rm[IW-1:0]] = i_push_data;
            n_cnt               = cnt_rm + CW'(1);
        end
    end

    always_comb begin
        o_found     = 1'b0;
        o_found_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!o_found && (CW'(i) < r_cnt) && (r_q[i] == i_key)) begin
                o_found     = 1'b1;
                o_found_idx = IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= INIT_FULL ? CW'(DEPTH) : '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_q[i] <= VOICE_W'(i);
            end
        end else begin
            r_cnt <= n_cnt;
            r_q   <= n_q;
        end
    end

    assign o_entries = r_q;
    assign o_count   = r_cnt;
endmodule

FILE: hw/rtl/pva_voice_cell.sv
// one voice: note, velocity, status and map bit, with note match
// depends on pva_pkg
`timescale 1ns / 1ps
module pva_voice_cell
    import pva_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_vc_ctrl          i_ctrl,
    input  logic [NOTE_W-1:0] i_key,
    input  logic [VEL_W-1:0]  i_vel,
    input  logic [ST_W-1:0]   i_st,
    output logic [NOTE_W-1:0] o_note,
    output logic [VEL_W-1:0]  o_vel,
    output logic [ST_W-1:0]   o_st,
    output logic              o_match
);
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic [ST_W-1:0]   r_st;
    logic              r_mapped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note   <= '0;
            r_vel    <= '0;
            r_st     <= VS_OFF;
            r_mapped <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_note   <= i_key;
                r_vel    <= i_vel;
                r_mapped <= 1'b1;
            end else if (i_ctrl.unmap) begin
                r_mapped <= 1'b0;
            end
            if (i_ctrl.set_st) begin
                r_st <= i_st;
            end
        end
    end

    assign o_note  = r_note;
    assign o_vel   = r_vel;
    assign o_st    = r_st;
    assign o_match = r_mapped && (r_note == i_key);
endmodule

FILE: bench/tb.sv
// self-checking bench for the voice allocator: driver, monitor and voice-state predictor
// depends on pva_pkg and polyphonic_voice_allocator
`timescale 1ns / 1ps
module tb
    import pva_pkg::*;
();

    localparam int NV = VOICES_DEF;
    localparam int NN = NOTES_DEF;

    typedef struct {
        logic [1:0]        cmd;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        bit                drain;   // hold off until nothing is outstanding
    } t_event;

    typedef struct {
        logic [VOICE_W-1:0] voice;
        logic [ACT_W-1:0]   action;
        logic [NOTE_W-1:0]  old_note;
        logic [VEL_W-1:0]   old_vel;
        logic               last;
    } t_alloc;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_cmd;
    logic [NOTE_W-1:0]  i_note;
    logic [VEL_W-1:0]   i_velocity;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [VOICE_W-1:0] o_voice;
    logic [ACT_W-1:0]   o_action;
    logic [NOTE_W-1:0]  o_old_note;
    logic [VEL_W-1:0]   o_old_velocity;
    logic               o_last;

    polyphonic_voice_allocator uut (.*);

    // mirror of the allocator state
    logic [VOICE_W-1:0] note_owner [NN];   // 0 none, else voice + 1
    logic [VOICE_W-1:0] free_row [NV];
    int                 free_hd, free_cnt;
    logic [VOICE_W-1:0] rel_row [NV];
    int                 rel_hd, rel_cnt;
    logic [VOICE_W-1:0] play_row [NV];
    int                 play_hd, play_cnt;
    logic [NOTE_W-1:0]  v_note [NV];
    logic [VEL_W-1:0]   v_vel [NV];
    logic [ST_W-1:0]    v_st [NV];

    t_event pending_events[$];
    t_alloc expected_allocs[$];
    int     n_accepted = 0;
    int     n_results = 0;
    int     n_errors = 0;
    int     act_seen [8] = '{default: 0};
    t_event cur;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int play_slot(int j);
        return (play_hd + NV - play_cnt + j) % NV;
    endfunction

    function automatic void expect_alloc(int v, logic [ACT_W-1:0] a, int on, int ov);
        t_alloc r;
        r.voice = VOICE_W'(v); r.action = a; r.old_note = NOTE_W'(on);
        r.old_vel = VEL_W'(ov); r.last = 1'b0;
        expected_allocs.push_back(r);
    endfunction

    function automatic void push_rel(int v);
        if (rel_cnt < NV) begin
            rel_row[(rel_hd + rel_cnt) % NV] = VOICE_W'(v);
            rel_cnt++;
        end
    endfunction

    // removes a voice from the playing ring, closing the gap
    function automatic bit play_remove(int v);
        for (int j = 0; j < play_cnt; j++) begin
            if (play_row[play_slot(j)] == v) begin
                for (int k = j; k + 1 < play_cnt; k++)
                    play_row[play_slot(k)] = play_row[play_slot(k + 1)];
                play_cnt--;
                play_hd = (play_hd + NV - 1) % NV;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void reset_voices();
        foreach (note_owner[i]) note_owner[i] = '0;
        for (int i = 0; i < NV; i++) begin
            free_row[i] = VOICE_W'(i); rel_row[i] = '0; play_row[i] = '0;
            v_note[i] = '0; v_vel[i] = '0; v_st[i] = VS_OFF;
        end
        free_hd = 0; free_cnt = NV;
        rel_hd = 0; rel_cnt = 0;
        play_hd = 0; play_cnt = 0;
    endfunction

    // predicts ticks, retriggers, note offs and unknown commands
    function automatic void allocate_event(t_event e);
        int m, v, n, n_before;
        n_before = expected_allocs.size();
        m = note_owner[e.note];
        if (e.cmd == CMD_TICK) begin
            n = rel_cnt;
            while (n > 0 && rel_cnt > 0) begin
                n--;
                v = rel_row[rel_hd] % NV;
                rel_hd = (rel_hd + 1) % NV;
                rel_cnt--;
                if (v_st[v] == VS_OFF) begin
                    note_owner[v_note[v]] = '0;
                    if (free_cnt < NV) begin
                        free_row[(free_hd + free_cnt) % NV] = VOICE_W'(v);
                        free_cnt++;
                    end
                    expect_alloc(v, ACT_FREED, 0, v_vel[v]);
                end else begin
                    v_st[v] = VS_OFF;
                    push_rel(v);
                    expect_alloc(v, ACT_MARKED, 0, v_vel[v]);
                end
            end
        end else if (e.cmd == CMD_ON) begin
            // fresh notes go through note_event, only a retrigger lands here
            if (m > 0 && m - 1 < NV) begin
                v = m - 1;
                v_st[v] = VS_RETRIGGER;   // velocity kept on retrigger
                expect_alloc(v, ACT_RETRIGGER, 0, v_vel[v]);
            end else begin
                expect_alloc(0, ACT_IGNORED, 0, 0);
            end
        end else if (e.cmd == CMD_OFF) begin
            if (m == 0 || m - 1 >= NV || !play_remove(m - 1)) begin
                expect_alloc(0, ACT_IGNORED, 0, 0);
            end else begin
                v = m - 1;
                v_st[v] = VS_RELEASE;
                push_rel(v);
                expect_alloc(v, ACT_RELEASE, 0, v_vel[v]);
            end
        end else begin
            expect_alloc(0, ACT_IGNORED, 0, 0);
        end
        if (expected_allocs.size() > n_before)
            expected_allocs[expected_allocs.size() - 1].last = 1'b1;
    endfunction

    // full note-on path including steals
    function automatic void note_event(t_event e);
        int m, v, oldn;
        logic [ACT_W-1:0] a;
        m = note_owner[e.note];
        if (e.cmd != CMD_ON || (m > 0 && m - 1 < NV)) begin
            allocate_event(e);
            return;
        end
        v = -1;
        oldn = 0;
        a = ACT_IGNORED;
        if (free_cnt > 0) begin
            v = free_row[free_hd] % NV;
            free_hd = (free_hd + 1) % NV;
            free_cnt--;
            a = ACT_TRIGGER;
            v_st[v] = VS_TRIGGER;
        end else if (rel_cnt > 0 || play_cnt > 0) begin
            if (rel_cnt > 0) begin
                v = rel_row[rel_hd] % NV;
                rel_hd = (rel_hd + 1) % NV;
                rel_cnt--;
            end else begin
                v = play_row[play_slot(0)] % NV;
                play_cnt--;
            end
            a = ACT_STEAL;
            v_st[v] = VS_STEAL;
            oldn = v_note[v];
            note_owner[oldn] = '0;   // stolen note loses its voice
        end
        if (v < 0) begin
            expect_alloc(0, ACT_IGNORED, 0, 0);
        end else begin
            expect_alloc(v, a, oldn, v_vel[v]);
            v_note[v] = e.note;
            v_vel[v] = e.vel;
            note_owner[e.note] = VOICE_W'(v + 1);
            play_row[play_hd] = VOICE_W'(v);
            if (play_cnt < NV) play_cnt++;
            play_hd = (play_hd + 1) % NV;
        end
        expected_allocs[expected_allocs.size() - 1].last = 1'b1;
    endfunction

    // sender idles 34 and receiver 65 percent, then swapped, then no idling
    function automatic int idle_pct(bit sender);
        if (n_accepted < 120) return sender ? 34 : 65;
        if (n_accepted < 240) return sender ? 65 : 34;
        return 0;
    endfunction

    // driver: presents queued commands and predicts on each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                note_event(cur);
                n_accepted++;
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)
                    && !(pending_events[0].drain && expected_allocs.size() > 0)) begin
                    cur = pending_events.pop_front();
                    i_cmd      <= cur.cmd;
                    i_note     <= cur.note;
                    i_velocity <= cur.vel;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_alloc x;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (expected_allocs.size() == 0) begin
                $error("unexpected result voice %0d action %0d", o_voice, o_action);
                n_errors++;
            end else begin
                x = expected_allocs.pop_front();
                act_seen[x.action]++;
                if (o_voice !== x.voice) begin
                    $error("voice: expected %0d got %0d", x.voice, o_voice);
                    n_errors++;
                end
                if (o_action !== x.action) begin
                    $error("action: expected %0d got %0d", x.action, o_action);
                    n_errors++;
                end
                if (o_old_note !== x.old_note) begin
                    $error("old_note: expected %0d got %0d", x.old_note, o_old_note);
                    n_errors++;
                end
                if (o_old_velocity !== x.old_vel) begin
                    $error("old_velocity: expected %0d got %0d", x.old_vel, o_old_velocity);
                    n_errors++;
                end
                if (o_last !== x.last) begin
                    $error("last: expected %0d got %0d", x.last, o_last);
                    n_errors++;
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    function automatic void queue_event(logic [1:0] c, int n, int v, bit d = 1'b0);
        t_event e;
        e.cmd = c; e.note = NOTE_W'(n); e.vel = VEL_W'(v); e.drain = d;
        pending_events.push_back(e);
    endfunction

    initial begin
        int base, r, c;
        i_rst_n = 1'b0;
        reset_voices();

        // directed: field extremes, retrigger, double release, unknown command, aging
        queue_event(CMD_ON, 0, 127);
        queue_event(CMD_ON, 127, 0);
        queue_event(CMD_ON, 0, 55);         // retrigger keeps velocity
        queue_event(CMD_OFF, 127, 0);
        queue_event(CMD_OFF, 127, 0);       // already released: ignored
        queue_event(CMD_ON, 127, 99);       // retrigger of a released voice
        queue_event(CMD_OFF, 9, 127);       // unassigned note: ignored
        queue_event(2'd3, 127, 127);        // unknown command
        queue_event(CMD_TICK, 0, 0);
        queue_event(CMD_TICK, 127, 127);
        queue_event(CMD_TICK, 0, 0);
        queue_event(CMD_TICK, 0, 0);        // empty released queue: no result
        for (int i = 0; i < 13; i++)        // take all but one of the free voices
            queue_event(CMD_ON, 20 + i, i * 9);
        queue_event(CMD_OFF, 20, 0, 1'b1);
        queue_event(CMD_ON, 60, 127);

        // random: mostly a narrow window of notes so offs and retriggers hit
        base = $urandom_range(0, 104);
        for (int i = 0; i < 350; i++) begin
            if ($urandom_range(19) == 0) base = $urandom_range(0, 104);
            r = $urandom_range(99);
            c = (r < 45) ? CMD_ON : (r < 80) ? CMD_OFF : (r < 97) ? CMD_TICK : 3;
            queue_event(2'(c), ($urandom_range(9) == 0) ? $urandom_range(127)
                                                        : base + $urandom_range(23),
                        $urandom_range(127), (i == 175));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_events.size() == 0);
        @(posedge i_clk);
        while (i_in_valid || expected_allocs.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d commands, %0d results: trig %0d retrig %0d steal %0d rel %0d",
                 n_accepted, n_results, act_seen[ACT_TRIGGER], act_seen[ACT_RETRIGGER],
                 act_seen[ACT_STEAL], act_seen[ACT_RELEASE]);
        $display("aging: marked off %0d, freed %0d; ignored %0d",
                 act_seen[ACT_MARKED], act_seen[ACT_FREED], act_seen[ACT_IGNORED]);
        if (n_errors == 0 && expected_allocs.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #(20 * 400000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
